// ===== rtl/tpam_pkg.sv =====
// ----------------------------------------------------------------------------
// tpam_pkg
// Shared types and codes for the three-port AHB master arbiter.
// ----------------------------------------------------------------------------
package tpam_pkg;

	localparam int AddrW   = 32;
	localparam int MapW    = 16;
	localparam int CfgIdxW = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_MAP  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LINE = 2'd1;

	// owner codes
	localparam logic [1:0] OWN_INST = 2'd0;
	localparam logic [1:0] OWN_DATA = 2'd1;
	localparam logic [1:0] OWN_WALK = 2'd2;
	localparam logic [1:0] OWN_NONE = 2'd3;

	// htrans
	localparam logic [1:0] TR_IDLE   = 2'd0;
	localparam logic [1:0] TR_NONSEQ = 2'd2;
	localparam logic [1:0] TR_SEQ    = 2'd3;

	// hresp
	localparam logic [1:0] RESP_OK    = 2'd0;
	localparam logic [1:0] RESP_ERR   = 2'd1;
	localparam logic [1:0] RESP_RETRY = 2'd2;
	localparam logic [1:0] RESP_SPLIT = 2'd3;

	// hsize
	localparam logic [1:0] SIZE_WORD  = 2'd2;
	localparam logic [1:0] SIZE_DWORD = 2'd3;

	typedef struct packed {
		logic [MapW-1:0] cacheable_map;
		logic            line_is_eight_words;
	} cfg_t;

	typedef struct packed {
		logic             inst_request;
		logic [AddrW-1:0] inst_address;
		logic [1:0]       inst_flags;
		logic             data_request;
		logic [AddrW-1:0] data_address;
		logic [6:0]       data_flags;
		logic             walk_request;
		logic [AddrW-1:0] walk_address;
		logic [3:0]       walk_flags;
		logic             bus_ready;
		logic [1:0]       bus_response;
		logic             bus_granted;
	} item_t;

	typedef struct packed {
		logic [1:0] owner;
		logic       active;
		logic       granted;
		logic       retry_now;
		logic       retry_held;
		logic       write_error;
		logic       last_beat;
		logic       access_cacheable;
		logic       lock_held;
		logic       nonseq_pending;
		logic [1:0] next_owner;
	} state_t;

	typedef struct packed {
		logic [AddrW-1:0] bus_addr;
		logic [1:0]       bus_trans;
		logic             bus_request;
		logic             bus_lock;
		logic             bus_write;
		logic [1:0]       bus_size;
		logic             bus_burst;
		logic [3:0]       bus_prot;
		logic [4:0]       inst_status;
		logic [7:0]       data_status;
		logic [5:0]       walk_status;
	} result_t;

endpackage

// ===== rtl/tpam_step.sv =====
// ----------------------------------------------------------------------------
// tpam_step
// One bus clock of arbitration, address sequencing and response decode.
// ----------------------------------------------------------------------------
module tpam_step import tpam_pkg::*; (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	function automatic logic [AddrW-1:0] next_beat(input logic [AddrW-1:0] a);
		logic [2:0] b;
		b = a[4:2] + 3'd1;
		return {a[AddrW-1:5], b, a[1:0]};
	endfunction

	logic       map_on;
	logic       dread, dlock, dburst, dcache, duser;
	logic [1:0] dsize;
	logic       wread, wlock;
	logic [1:0] wsize;
	logic       hready;
	logic       resp_retry;
	logic       dec_data, i_cache_fix, w_cache_fix;

	logic [1:0]       nbo;
	logic [1:0]       trans;
	logic             busreq;
	logic [AddrW-1:0] addr;
	logic             wr, lock, burst, su;
	logic [1:0]       size;
	logic             ig, ir, ie, it, ic;
	logic             dg, dr, de, dt, dc;
	logic             mg, mr, me, mt, mc;
	logic             n_werr, n_last, n_cache, n_retry, n_retry_held;
	logic [1:0]       n_owner;
	logic             n_active, n_granted, n_lock;
	logic             single, breq;

	always_comb begin
		map_on = cfg.cacheable_map != '0;
		dread  = item.data_flags[0];
		dsize  = item.data_flags[2:1];
		dlock  = item.data_flags[3];
		dburst = item.data_flags[4];
		dcache = item.data_flags[5];
		duser  = item.data_flags[6];
		wread  = item.walk_flags[0];
		wsize  = item.walk_flags[2:1];
		wlock  = item.walk_flags[3];
		hready = item.bus_ready;
		resp_retry = item.bus_response[1];

		dec_data    = map_on & cfg.cacheable_map[item.data_address[31:28]];
		i_cache_fix = map_on ? cfg.cacheable_map[item.inst_address[31:28]] : 1'b1;
		w_cache_fix = map_on ? cfg.cacheable_map[item.walk_address[31:28]] : 1'b1;

		trans  = TR_IDLE;
		busreq = 1'b0;
		addr   = '0;
		wr     = 1'b0;
		size   = 2'd0;
		lock   = 1'b0;
		burst  = 1'b0;
		su     = 1'b0;
		{ig, ir, ie, it, ic} = '0;
		{dg, dr, de, dt, dc} = '0;
		{mg, mr, me, mt, mc} = '0;
		n_werr  = 1'b0;
		n_cache = st.access_cacheable;
		n_last  = hready ? 1'b0 : st.last_beat;
		n_retry_held = (st.retry_now | st.retry_held) & ~(st.active & ~st.retry_now);

		// fixed priority I, D, MMU; an active owner keeps the bus from the others
		if (item.inst_request && !st.lock_held &&
				!((st.active && item.data_request && st.owner == OWN_DATA) ||
				  (st.active && item.walk_request && st.owner == OWN_WALK))) begin
			nbo = OWN_INST; busreq = 1'b1; trans = TR_NONSEQ;
		end else if (item.data_request &&
				!((st.active && item.inst_request && st.owner == OWN_INST) ||
				  (st.active && item.walk_request && st.owner == OWN_WALK))) begin
			nbo = OWN_DATA; busreq = 1'b1;
			if (!dlock || st.lock_held)
				trans = TR_NONSEQ;
		end else if (item.walk_request && !st.lock_held &&
				!((st.active && item.inst_request && st.owner == OWN_INST) ||
				  (st.active && item.data_request && st.owner == OWN_DATA))) begin
			nbo = OWN_WALK; busreq = 1'b1; trans = TR_NONSEQ;
		end else begin
			nbo = OWN_NONE;
		end
		if (st.nonseq_pending) begin
			nbo = st.next_owner; busreq = 1'b1; trans = TR_NONSEQ;
		end
		if (st.retry_held && !st.active) begin
			nbo = st.owner; busreq = 1'b1; trans = TR_NONSEQ;
		end

		case (nbo)
			OWN_WALK: begin
				addr  = item.walk_address;
				wr    = ~wread;
				size  = wsize;
				lock  = wlock;
				trans = TR_NONSEQ;
				if (item.walk_request && st.granted && hready && !st.retry_now) begin
					mg = 1'b1; n_cache = w_cache_fix;
				end
			end
			OWN_INST: begin
				addr = item.inst_address;
				su   = item.inst_flags[1];
				size = SIZE_WORD;
				if (item.inst_request && st.active && st.owner == OWN_INST &&
						!st.retry_now) begin
					trans = TR_SEQ;
					addr  = next_beat(item.inst_address);
					// beat before the line end
					if (((!cfg.line_is_eight_words && addr[3:2] == 2'd2) ||
						 (cfg.line_is_eight_words && addr[4:2] == 3'd6)) && hready)
						n_last = 1'b1;
				end
				burst = item.inst_flags[0];
				if (item.inst_request && st.granted && hready && !st.retry_now) begin
					ig = 1'b1; n_cache = i_cache_fix;
				end
			end
			OWN_DATA: begin
				addr  = item.data_address;
				wr    = ~dread;
				size  = dsize;
				lock  = dlock;
				su    = ~duser;
				burst = dburst;
				if (item.data_request && st.active && st.owner == OWN_DATA &&
						!st.retry_now) begin
					trans = TR_SEQ;
					addr  = next_beat(item.data_address);
					burst = 1'b1;
				end
				if (item.data_request && st.granted && hready && !st.retry_now) begin
					dg = ~dlock | st.lock_held | st.retry_held;
					n_cache = dec_data;
				end
			end
			default: begin
			end
		endcase

		n_retry = st.active & resp_retry & ~hready;
		if (st.retry_now)
			trans = TR_IDLE;

		case (st.owner)
			OWN_WALK: begin
				if (st.active) begin
					mc = st.access_cacheable;
					if (hready) begin
						if (item.bus_response == RESP_OK) begin
							mr = 1'b1;
						end else if (item.bus_response == RESP_ERR) begin
							mr = 1'b1; me = 1'b1; n_werr = ~wread;
						end else begin
							mt = 1'b1;
						end
					end
				end
			end
			OWN_INST: begin
				if (st.active) begin
					ic = st.access_cacheable;
					if (hready) begin
						if (item.bus_response == RESP_OK) begin
							ir = 1'b1;
						end else if (item.bus_response == RESP_ERR) begin
							ir = 1'b1; ie = 1'b1;
						end else begin
							it = 1'b1;
						end
					end
				end
			end
			OWN_DATA: begin
				if (st.active) begin
					dc = st.access_cacheable;
					if (hready) begin
						if (item.bus_response == RESP_OK) begin
							dr = 1'b1;
						end else if (item.bus_response == RESP_ERR) begin
							dr = 1'b1; de = 1'b1; n_werr = ~dread;
						end else begin
							dt = 1'b1;
						end
					end
				end
				lock = dlock | ((st.retry_now | (st.retry_held & ~st.active)) & st.lock_held);
			end
			default: begin
			end
		endcase

		// doubleword data accesses and cacheable data reads go out as words
		if (nbo == OWN_DATA && (size == SIZE_DWORD || (dec_data & dread & dcache))) begin
			size = SIZE_WORD;
			addr[1:0] = 2'b00;
		end
		if (st.owner == OWN_DATA && lock)
			nbo = OWN_DATA;

		n_owner   = st.owner;
		n_granted = st.granted;
		n_active  = st.active;
		n_lock    = st.lock_held;
		if (hready) begin
			if (!st.retry_now)
				n_owner = nbo;
			n_granted = item.bus_granted;
			n_active  = (trans == TR_NONSEQ || trans == TR_SEQ) ? st.granted : 1'b0;
			n_lock    = lock & item.bus_granted;
		end
		single = ~burst;
		breq = busreq & ~st.last_beat &
			~((((st.owner != OWN_INST) & st.active) | single) & st.granted);

		res.bus_addr    = addr;
		res.bus_trans   = trans;
		res.bus_request = breq;
		res.bus_lock    = lock;
		res.bus_write   = wr;
		res.bus_size    = size;
		res.bus_burst   = burst;
		res.bus_prot    = {2'b11, su, nbo != OWN_INST};
		res.inst_status = {ic, it, ie, ir, ig};
		res.data_status = {st.granted & ~n_owner[1], st.active, dc, st.write_error,
			dt, de, dr, dg};
		res.walk_status = {mc, st.write_error, mt, me, mr, mg};

		nxt.owner            = n_owner;
		nxt.active           = n_active;
		nxt.granted          = n_granted;
		nxt.retry_now        = n_retry;
		nxt.retry_held       = n_retry_held;
		nxt.write_error      = n_werr;
		nxt.last_beat        = n_last;
		nxt.access_cacheable = n_cache;
		nxt.lock_held        = n_lock;
		// pending only while the next clock still has no active transfer
		nxt.nonseq_pending   = (trans != TR_IDLE) & ~n_active;
		nxt.next_owner       = nbo;
	end

endmodule

// ===== rtl/three_port_ahb_master_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// three_port_ahb_master_arbiter_top
// Shares one AHB master port among I-cache, D-cache and MMU table walk.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | requests, addresses, flags, hready/hresp/hgrant
//  out     | out_valid/out_ready| AHB address/control, per-port status
//  cfg     | cfg_we             | cfg_index, cfg_data (no read-back)
//
// One item per cycle while the output is not stalled; an item is registered,
// evaluated against the bus state in one pass and its result is offered from the result register.
// The result register stalls the input register, which stalls the input.
// Reset clears the bus state, both valid flags and the config registers.
// ----------------------------------------------------------------------------
module three_port_ahb_master_arbiter_top import tpam_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               inst_request,
	input  logic [AddrW-1:0]   inst_address,
	input  logic [1:0]         inst_flags,
	input  logic               data_request,
	input  logic [AddrW-1:0]   data_address,
	input  logic [6:0]         data_flags,
	input  logic               walk_request,
	input  logic [AddrW-1:0]   walk_address,
	input  logic [3:0]         walk_flags,
	input  logic               bus_ready,
	input  logic [1:0]         bus_response,
	input  logic               bus_granted,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [AddrW-1:0]   bus_addr,
	output logic [1:0]         bus_trans,
	output logic               bus_request,
	output logic               bus_lock,
	output logic               bus_write,
	output logic [1:0]         bus_size,
	output logic               bus_burst,
	output logic [3:0]         bus_prot,
	output logic [4:0]         inst_status,
	output logic [7:0]         data_status,
	output logic [5:0]         walk_status,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [MapW-1:0]    cfg_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP:  cfg_q.cacheable_map <= cfg_data;
				CFG_LINE: cfg_q.line_is_eight_words <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{inst_request, inst_address, inst_flags,
				data_request, data_address, data_flags,
				walk_request, walk_address, walk_flags,
				bus_ready, bus_response, bus_granted};
		end
	end

	tpam_step u_step (
		.item (item_s1),
		.st   (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid   = out_valid_q;
	assign bus_addr    = res_q.bus_addr;
	assign bus_trans   = res_q.bus_trans;
	assign bus_request = res_q.bus_request;
	assign bus_lock    = res_q.bus_lock;
	assign bus_write   = res_q.bus_write;
	assign bus_size    = res_q.bus_size;
	assign bus_burst   = res_q.bus_burst;
	assign bus_prot    = res_q.bus_prot;
	assign inst_status = res_q.inst_status;
	assign data_status = res_q.data_status;
	assign walk_status = res_q.walk_status;

endmodule

// ===== rtl/tpam_checker.sv =====
// ----------------------------------------------------------------------------
// tpam_checker
// Port-level checks for the three-port AHB master arbiter.
// ----------------------------------------------------------------------------
module tpam_checker import tpam_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [AddrW-1:0] bus_addr,
	input logic [1:0]       bus_trans,
	input logic [3:0]       bus_prot,
	input logic [4:0]       inst_status,
	input logic [7:0]       data_status,
	input logic [5:0]       walk_status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_addr))
		else $error("result changed while stalled");

	// the master never issues BUSY
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bus_trans != 2'd1)
		else $error("BUSY transfer driven");

	// at most one requester is granted per item
	a_one_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({inst_status[0], data_status[0], walk_status[0]}) <= 1)
		else $error("more than one port granted");

	// hprot bits 3:2 are always driven high
	a_prot_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bus_prot[3:2] == 2'b11)
		else $error("hprot upper bits not set");

endmodule

bind three_port_ahb_master_arbiter_top tpam_checker u_tpam_checker (.*);

// ===== tb/tpam_bus_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpam_bus_checker
// Watches the item channels and the register port of the AHB master arbiter.
// Every accepted item is run through a cycle model of the arbiter to predict
// the bus clock it produces; accepted results are matched field by field
// against those predictions in order.
// ----------------------------------------------------------------------------
module tpam_bus_checker
	import tpam_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               inst_request,
	input  logic [AddrW-1:0]   inst_address,
	input  logic [1:0]         inst_flags,
	input  logic               data_request,
	input  logic [AddrW-1:0]   data_address,
	input  logic [6:0]         data_flags,
	input  logic               walk_request,
	input  logic [AddrW-1:0]   walk_address,
	input  logic [3:0]         walk_flags,
	input  logic               bus_ready,
	input  logic [1:0]         bus_response,
	input  logic               bus_granted,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [AddrW-1:0]   bus_addr,
	input  logic [1:0]         bus_trans,
	input  logic               bus_request,
	input  logic               bus_lock,
	input  logic               bus_write,
	input  logic [1:0]         bus_size,
	input  logic               bus_burst,
	input  logic [3:0]         bus_prot,
	input  logic [4:0]         inst_status,
	input  logic [7:0]         data_status,
	input  logic [5:0]         walk_status,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [MapW-1:0]    cfg_data,
	output int                 fail_count,
	output int                 results_pending
);

	cfg_t    map_cfg;
	state_t  bus_st;
	result_t expected_bus_q[$];

	function automatic logic [31:0] next_beat_addr(input logic [31:0] a);
		next_beat_addr = {a[31:5], a[4:2] + 3'd1, a[1:0]};
	endfunction

	function automatic logic region_bit(input logic [31:0] a);
		region_bit = map_cfg.cacheable_map[a[31:28]];
	endfunction

	// instruction and walk accesses are cacheable when the map is empty
	function automatic logic fixed_cacheable(input logic [31:0] a);
		fixed_cacheable = (map_cfg.cacheable_map != '0) ? region_bit(a) : 1'b1;
	endfunction

	// {retry, error, ready}
	function automatic logic [2:0] response_flags(input logic [1:0] resp);
		case (resp)
		RESP_OK:  response_flags = 3'b001;
		RESP_ERR: response_flags = 3'b011;
		default:  response_flags = 3'b100;
		endcase
	endfunction

	function automatic result_t predict_bus_clock(input item_t it);
		state_t      s;
		result_t     r;
		logic [1:0]  n_owner, nbo, trans, size;
		logic        n_active, n_granted, n_retry, n_retry_held, n_werr;
		logic        n_last, n_cache, n_lock;
		logic        busreq, wr, lock, burst, su, dec_data, breq;
		logic        dread, dlock, dburst, dcache, duser, wread, wlock;
		logic [1:0]  dsize, wsize;
		logic [31:0] addr;
		logic [3:0]  i_evt, d_evt, w_evt;
		logic        i_c, d_c, w_c;

		s = bus_st;
		dread = it.data_flags[0];
		dsize = it.data_flags[2:1];
		dlock = it.data_flags[3];
		dburst = it.data_flags[4];
		dcache = it.data_flags[5];
		duser = it.data_flags[6];
		wread = it.walk_flags[0];
		wsize = it.walk_flags[2:1];
		wlock = it.walk_flags[3];

		n_owner = s.owner;
		n_active = s.active;
		n_granted = s.granted;
		n_werr = 1'b0;
		n_last = it.bus_ready ? 1'b0 : s.last_beat;
		n_cache = s.access_cacheable;
		n_lock = s.lock_held;
		n_retry_held = (s.retry_now | s.retry_held) & ~(s.active & ~s.retry_now);
		trans = TR_IDLE;
		busreq = 1'b0;
		addr = '0;
		wr = 1'b0;
		size = 2'd0;
		lock = 1'b0;
		burst = 1'b0;
		su = 1'b0;
		i_evt = '0;
		d_evt = '0;
		w_evt = '0;
		i_c = 1'b0;
		d_c = 1'b0;
		w_c = 1'b0;

		// base priority I, D, MMU; a busy owner keeps the bus from the others
		if (it.inst_request && !s.lock_held &&
			!((s.active && it.data_request && s.owner == OWN_DATA) ||
			(s.active && it.walk_request && s.owner == OWN_WALK))) begin
			nbo = OWN_INST;
			busreq = 1'b1;
			trans = TR_NONSEQ;
		end else if (it.data_request &&
			!((s.active && it.inst_request && s.owner == OWN_INST) ||
			(s.active && it.walk_request && s.owner == OWN_WALK))) begin
			nbo = OWN_DATA;
			busreq = 1'b1;
			if (!dlock || s.lock_held)
				trans = TR_NONSEQ;
		end else if (it.walk_request && !s.lock_held &&
			!((s.active && it.inst_request && s.owner == OWN_INST) ||
			(s.active && it.data_request && s.owner == OWN_DATA))) begin
			nbo = OWN_WALK;
			busreq = 1'b1;
			trans = TR_NONSEQ;
		end else begin
			nbo = OWN_NONE;
		end
		if (s.nonseq_pending) begin
			nbo = s.next_owner;
			busreq = 1'b1;
			trans = TR_NONSEQ;
		end
		if (s.retry_held && !s.active) begin
			nbo = s.owner;
			busreq = 1'b1;
			trans = TR_NONSEQ;
		end

		dec_data = (map_cfg.cacheable_map != '0) ? region_bit(it.data_address) : 1'b0;

		case (nbo)
		OWN_WALK: begin
			addr = it.walk_address;
			wr = ~wread;
			size = wsize;
			lock = wlock;
			trans = TR_NONSEQ;
			if (it.walk_request && s.granted && it.bus_ready && !s.retry_now) begin
				w_evt[0] = 1'b1;
				n_cache = fixed_cacheable(addr);
			end
		end
		OWN_INST: begin
			addr = it.inst_address;
			su = it.inst_flags[1];
			size = SIZE_WORD;
			if (it.inst_request && s.active && s.owner == OWN_INST && !s.retry_now) begin
				trans = TR_SEQ;
				addr = next_beat_addr(addr);
				// second to last word of a 4- or 8-word line
				if (((!map_cfg.line_is_eight_words && addr[3:2] == 2'd2) ||
					(map_cfg.line_is_eight_words && addr[4:2] == 3'd6)) && it.bus_ready)
					n_last = 1'b1;
			end
			burst = it.inst_flags[0];
			if (it.inst_request && s.granted && it.bus_ready && !s.retry_now) begin
				i_evt[0] = 1'b1;
				n_cache = fixed_cacheable(addr);
			end
		end
		OWN_DATA: begin
			addr = it.data_address;
			wr = ~dread;
			size = dsize;
			lock = dlock;
			su = ~duser;
			burst = dburst;
			if (it.data_request && s.active && s.owner == OWN_DATA && !s.retry_now) begin
				trans = TR_SEQ;
				addr = next_beat_addr(addr);
				burst = 1'b1;
			end
			if (it.data_request && s.granted && it.bus_ready && !s.retry_now) begin
				d_evt[0] = ~dlock | s.lock_held | s.retry_held;
				n_cache = dec_data;
			end
		end
		default: ;
		endcase

		n_retry = (s.active && (it.bus_response == RESP_RETRY ||
			it.bus_response == RESP_SPLIT)) ? ~it.bus_ready : 1'b0;
		if (s.retry_now)
			trans = TR_IDLE;

		case (s.owner)
		OWN_WALK: begin
			if (s.active) begin
				w_c = s.access_cacheable;
				if (it.bus_ready) begin
					w_evt[3:1] = response_flags(it.bus_response);
					if (it.bus_response == RESP_ERR)
						n_werr = ~wread;
				end
			end
		end
		OWN_INST: begin
			if (s.active) begin
				i_c = s.access_cacheable;
				if (it.bus_ready)
					i_evt[3:1] = response_flags(it.bus_response);
			end
		end
		OWN_DATA: begin
			if (s.active) begin
				d_c = s.access_cacheable;
				if (it.bus_ready) begin
					d_evt[3:1] = response_flags(it.bus_response);
					if (it.bus_response == RESP_ERR)
						n_werr = ~dread;
				end
			end
			lock = dlock | ((s.retry_now | (s.retry_held & ~s.active)) & s.lock_held);
		end
		default: ;
		endcase

		// doubleword data accesses and cacheable data reads go out as words
		if (nbo == OWN_DATA && (size == SIZE_DWORD || (dec_data & dread & dcache))) begin
			size = SIZE_WORD;
			addr[1:0] = 2'b00;
		end
		if (s.owner == OWN_DATA && lock)
			nbo = OWN_DATA;

		if (it.bus_ready) begin
			if (!s.retry_now)
				n_owner = nbo;
			n_granted = it.bus_granted;
			n_active = (trans == TR_NONSEQ || trans == TR_SEQ) ? s.granted : 1'b0;
			n_lock = lock & it.bus_granted;
		end

		breq = busreq & ~s.last_beat &
			~((((s.owner != OWN_INST) & s.active) | ~burst) & s.granted);

		r.bus_addr = addr;
		r.bus_trans = trans;
		r.bus_request = breq;
		r.bus_lock = lock;
		r.bus_write = wr;
		r.bus_size = size;
		r.bus_burst = burst;
		r.bus_prot = {2'b11, su, nbo != OWN_INST};
		r.inst_status = {i_c, i_evt};
		r.data_status = {s.granted & ~n_owner[1], s.active, d_c, s.write_error, d_evt};
		r.walk_status = {w_c, s.write_error, w_evt};

		bus_st.owner = n_owner;
		bus_st.active = n_active;
		bus_st.granted = n_granted;
		bus_st.retry_now = n_retry;
		bus_st.retry_held = n_retry_held;
		bus_st.write_error = n_werr;
		bus_st.last_beat = n_last;
		bus_st.access_cacheable = n_cache;
		bus_st.lock_held = n_lock;
		bus_st.next_owner = nbo;
		bus_st.nonseq_pending = (trans != TR_IDLE) & ~n_active;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			if (fail_count < 10)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;

		if (!arst_n) begin
			map_cfg = '0;
			bus_st = '0;
			expected_bus_q.delete();
			fail_count = 0;
			results_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {bus_addr, bus_trans, bus_request, bus_lock, bus_write, bus_size,
					bus_burst, bus_prot, inst_status, data_status, walk_status};
				if (expected_bus_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result item %h", $time, got);
					fail_count++;
				end else begin
					want = expected_bus_q.pop_front();
					check_field("bus_addr", want.bus_addr, got.bus_addr);
					check_field("bus_trans", want.bus_trans, got.bus_trans);
					check_field("bus_request", want.bus_request, got.bus_request);
					check_field("bus_lock", want.bus_lock, got.bus_lock);
					check_field("bus_write", want.bus_write, got.bus_write);
					check_field("bus_size", want.bus_size, got.bus_size);
					check_field("bus_burst", want.bus_burst, got.bus_burst);
					check_field("bus_prot", want.bus_prot, got.bus_prot);
					check_field("inst_status", want.inst_status, got.inst_status);
					check_field("data_status", want.data_status, got.data_status);
					check_field("walk_status", want.walk_status, got.walk_status);
				end
			end
			if (in_valid && in_ready)
				expected_bus_q.push_back(predict_bus_clock(item_t'({inst_request,
					inst_address, inst_flags, data_request, data_address, data_flags,
					walk_request, walk_address, walk_flags, bus_ready, bus_response,
					bus_granted})));
			if (cfg_we) begin
				case (cfg_index)
				CFG_MAP:  map_cfg.cacheable_map = cfg_data;
				CFG_LINE: map_cfg.line_is_eight_words = cfg_data[0];
				default: ;
				endcase
			end
			results_pending = expected_bus_q.size();
		end
	end

endmodule

// ===== tb/tb_three_port_ahb_master_arbiter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_port_ahb_master_arbiter_top
// Drives bus clocks into the arbiter: a directed opener covering field
// extremes, every requester, response and size rule, then sessions of
// held requests with random content and some noise under six register
// settings and three stall patterns. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_three_port_ahb_master_arbiter_top;
	import tpam_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SEG_ITEMS = 180;

	// indexes past the register list; writes there must be dropped
	localparam logic [CfgIdxW-1:0] CFG_RSVD2 = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_RSVD3 = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               inst_request;
	logic [AddrW-1:0]   inst_address;
	logic [1:0]         inst_flags;
	logic               data_request;
	logic [AddrW-1:0]   data_address;
	logic [6:0]         data_flags;
	logic               walk_request;
	logic [AddrW-1:0]   walk_address;
	logic [3:0]         walk_flags;
	logic               bus_ready;
	logic [1:0]         bus_response;
	logic               bus_granted;
	logic               out_valid;
	logic               out_ready;
	logic [AddrW-1:0]   bus_addr;
	logic [1:0]         bus_trans;
	logic               bus_request;
	logic               bus_lock;
	logic               bus_write;
	logic [1:0]         bus_size;
	logic               bus_burst;
	logic [3:0]         bus_prot;
	logic [4:0]         inst_status;
	logic [7:0]         data_status;
	logic [5:0]         walk_status;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [MapW-1:0]    cfg_data;
	int                 fail_count;
	int                 results_pending;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int quiet_cycles;

	three_port_ahb_master_arbiter_top uut (.*);

	tpam_bus_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		{inst_request, inst_address, inst_flags, data_request, data_address, data_flags,
			walk_request, walk_address, walk_flags, bus_ready, bus_response,
			bus_granted} <= it;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// register writes only with the arbiter drained
	task automatic write_register(input logic [CfgIdxW-1:0] idx,
		input logic [MapW-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_clock(input logic ireq, input logic [31:0] iaddr,
		input logic [1:0] ifl, input logic dreq, input logic [31:0] daddr,
		input logic [6:0] dfl, input logic wreq, input logic [31:0] waddr,
		input logic [3:0] wfl, input logic rdy, input logic [1:0] resp,
		input logic gnt);
		send_item(item_t'({ireq, iaddr, ifl, dreq, daddr, dfl, wreq, waddr, wfl,
			rdy, resp, gnt}));
	endtask

	// a run of bus clocks with held requests and advancing addresses
	task automatic run_session();
		item_t        it;
		logic [127:0] noise_bits;
		int           beats;
		bit           noisy;

		beats = $urandom_range(10, 2);
		noisy = ($urandom_range(99) < 15);
		it = '0;
		it.inst_request = ($urandom_range(99) < 60);
		it.data_request = ($urandom_range(99) < 45);
		it.walk_request = ($urandom_range(99) < 30);
		it.inst_address = $urandom;
		it.data_address = $urandom;
		it.walk_address = $urandom;
		it.inst_flags = 2'($urandom);
		it.data_flags = 7'($urandom);
		it.walk_flags = 4'($urandom);
		// locked data accesses stall the others, keep them rare
		if ($urandom_range(99) < 75)
			it.data_flags[3] = 1'b0;
		repeat (beats) begin
			if (noisy) begin
				noise_bits = {$urandom, $urandom, $urandom, $urandom};
				it = noise_bits[$bits(item_t)-1:0];
			end else begin
				it.bus_granted = ($urandom_range(99) < 90);
				it.bus_ready = ($urandom_range(99) < 80);
				it.bus_response = ($urandom_range(99) < 85) ? RESP_OK :
					2'($urandom_range(3));
			end
			send_item(it);
			if (!noisy && it.bus_ready) begin
				it.inst_address += 32'd4;
				it.data_address += 32'd4;
				it.walk_address += 32'd4;
			end
			if ($urandom_range(99) < 8)
				it.inst_request = ~it.inst_request;
			if ($urandom_range(99) < 8)
				it.data_request = ~it.data_request;
			if ($urandom_range(99) < 8)
				it.walk_request = ~it.walk_request;
		end
	endtask

	initial begin
		logic [MapW-1:0] map_val;
		logic            line_val;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{inst_request, inst_address, inst_flags, data_request, data_address, data_flags,
			walk_request, walk_address, walk_flags, bus_ready, bus_response,
			bus_granted} = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAP;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		write_register(CFG_MAP, 16'h0000);
		write_register(CFG_LINE, 1'b0);

		// no owner
		send_clock(0, '0, 2'b00, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		// instruction burst across a line, empty map counts as cacheable
		send_clock(1, 32'h0000_0000, 2'b11, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(1, 32'h0000_0000, 2'b11, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(1, 32'h0000_0004, 2'b11, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(1, 32'h0000_0008, 2'b11, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(1, 32'h0000_000C, 2'b11, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 1);
		// data, all flags and all address bits set
		send_clock(0, '0, 2'b00, 1, 32'hFFFF_FFFF, 7'h7F, 0, '0, 4'h0, 1, RESP_OK, 1);
		// doubleword read forced to word
		send_clock(0, '0, 2'b00, 1, 32'h8000_0007, {4'b0000, SIZE_DWORD, 1'b1},
			0, '0, 4'h0, 1, RESP_OK, 1);
		// data writes answered with error
		send_clock(0, '0, 2'b00, 1, 32'h1234_5678, {4'b0001, SIZE_WORD, 1'b0},
			0, '0, 4'h0, 1, RESP_ERR, 1);
		send_clock(0, '0, 2'b00, 1, 32'h1234_567C, {4'b0001, SIZE_WORD, 1'b0},
			0, '0, 4'h0, 1, RESP_ERR, 1);
		// table walk, then a walk write with error
		send_clock(0, '0, 2'b00, 0, '0, '0, 1, 32'hFFFF_FFFC, 4'hF, 1, RESP_OK, 1);
		send_clock(0, '0, 2'b00, 0, '0, '0, 1, 32'h0000_0000, 4'h0, 1, RESP_ERR, 1);
		// all three requesters against retry and split
		send_clock(1, 32'h4000_0000, 2'b01, 1, 32'h5000_0000, 7'h01, 1, 32'h6000_0000,
			4'h1, 0, RESP_RETRY, 1);
		send_clock(1, 32'h4000_0000, 2'b01, 1, 32'h5000_0000, 7'h01, 1, 32'h6000_0000,
			4'h1, 1, RESP_RETRY, 1);
		send_clock(1, 32'h4000_0000, 2'b01, 1, 32'h5000_0000, 7'h01, 1, 32'h6000_0000,
			4'h1, 0, RESP_SPLIT, 1);
		send_clock(1, 32'h4000_0000, 2'b01, 1, 32'h5000_0000, 7'h01, 1, 32'h6000_0000,
			4'h1, 1, RESP_OK, 1);
		send_clock(1, 32'h4000_0004, 2'b01, 1, 32'h5000_0004, 7'h01, 1, 32'h6000_0004,
			4'h1, 0, RESP_OK, 0);
		// locked data write held over consecutive clocks
		send_clock(0, '0, 2'b00, 1, 32'h7000_0000, {4'b0001, SIZE_WORD, 1'b0},
			1, 32'h7000_0100, 4'h1, 1, RESP_OK, 1);
		send_clock(1, 32'h2000_0000, 2'b00, 1, 32'h7000_0000, {4'b0001, SIZE_WORD, 1'b0},
			0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(1, 32'h2000_0000, 2'b00, 1, 32'h7000_0004, {4'b0001, SIZE_WORD, 1'b0},
			0, '0, 4'h0, 1, RESP_OK, 1);
		send_clock(0, '0, 2'b00, 0, '0, '0, 0, '0, 4'h0, 1, RESP_OK, 0);

		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 54 : 0;
			recv_idle_pct = (seg < 2) ? 54 : (seg < 4) ? 9 : 0;
			map_val = 16'($urandom);
			line_val = 1'($urandom);
			case (seg)
			0: begin map_val = 16'hFFFF; line_val = 1'b1; end
			1: line_val = 1'b0;
			2: begin map_val = 16'h0000; line_val = 1'b1; end
			3: line_val = 1'b1;
			4: begin
				map_val = 16'h8001;
				line_val = 1'b0;
				write_register(CFG_RSVD2, 16'hFFFF);
				write_register(CFG_RSVD3, 16'h5A5A);
			end
			default: ;
			endcase
			write_register(CFG_MAP, map_val);
			write_register(CFG_LINE, line_val);
			while (items_sent < 20 + (seg + 1) * SEG_ITEMS)
				run_session();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tpam_pkg.sv
rtl/tpam_step.sv
rtl/three_port_ahb_master_arbiter_top.sv
rtl/tpam_checker.sv
tb/tpam_bus_checker.sv
tb/tb_three_port_ahb_master_arbiter_top.sv
